/* sv/vptw_pkg.sv */
// Shared constants, register indexes and types of the vertex projection unit.
package vptw_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_W_EPSILON       = 3'd4;

    localparam logic signed [15:0] VP_X_RESET   = 16'sd0;
    localparam logic signed [15:0] VP_Y_RESET   = 16'sd0;
    localparam logic [14:0]        VP_W_RESET   = 15'd640;
    localparam logic [14:0]        VP_H_RESET   = 15'd480;
    localparam logic [15:0]        W_EPS_RESET  = 16'd1;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_PROJECT = 1'b1;

    localparam logic SEL_MODEL_VIEW = 1'b0;
    localparam logic SEL_PROJECTION = 1'b1;

    typedef struct packed {
        logic       mode;
        logic       sel;
        logic [1:0] row;
        logic [1:0] col;
    } t_ld;

endpackage

/* sv/vptw_in_if.sv */
// Vertex and coefficient load request channel.
interface vptw_in_if #(
    parameter int W = vptw_pkg::COORD_WIDTH
);
    logic                valid;
    logic                ready;
    logic                mode;
    logic                matrix_select;
    logic [1:0]          row_index;
    logic [1:0]          column_index;
    logic signed [W-1:0] coefficient;
    logic signed [W-1:0] obj_x;
    logic signed [W-1:0] obj_y;
    logic signed [W-1:0] obj_z;

    modport source (
        output valid, mode, matrix_select, row_index, column_index,
               coefficient, obj_x, obj_y, obj_z,
        input  ready
    );
    modport sink (
        input  valid, mode, matrix_select, row_index, column_index,
               coefficient, obj_x, obj_y, obj_z,
        output ready
    );
endinterface

/* sv/vptw_out_if.sv */
// Window coordinate result channel.
interface vptw_out_if #(
    parameter int W = vptw_pkg::COORD_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] win_x;
    logic signed [W-1:0] win_y;
    logic signed [W-1:0] win_z;
    logic                projected_ok;

    modport source (
        output valid, win_x, win_y, win_z, projected_ok,
        input  ready
    );
    modport sink (
        input  valid, win_x, win_y, win_z, projected_ok,
        output ready
    );
endinterface

/* sv/vptw_mat_stage.sv */
// Stored 4x4 matrix times vector: product stage then saturating row sums.
module vptw_mat_stage #(
    parameter int   W   = vptw_pkg::COORD_WIDTH,
    parameter int   F   = vptw_pkg::FRAC_BITS,
    parameter logic SEL = vptw_pkg::SEL_MODEL_VIEW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  vptw_pkg::t_ld       i_ld,
    input  logic signed [W-1:0] i_coef,
    input  logic signed [W-1:0] i_vec [4],
    output logic                o_valid,
    input  logic                i_ready,
    output vptw_pkg::t_ld       o_ld,
    output logic signed [W-1:0] o_coef,
    output logic signed [W-1:0] o_vec [4]
);
    localparam longint ONE_I = (F >= W - 1) ? ((longint'(1) <<< (W - 1)) - 1)
                                            : (longint'(1) <<< F);
    localparam logic signed [W-1:0] ONE  = W'(ONE_I);
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0]   r_mat [16];
    logic signed [2*W-1:0] r_prod [16];
    logic                  r_va;
    vptw_pkg::t_ld         r_ld_a;
    logic signed [W-1:0]   r_coef_a;
    logic                  r_vb;
    vptw_pkg::t_ld         r_ld_b;
    logic signed [W-1:0]   r_coef_b;
    logic signed [W-1:0]   r_vec_b [4];
    logic signed [W-1:0]   n_vec_b [4];
    logic                  en_a;
    logic                  en_b;
    logic                  wr;

    function automatic logic signed [W-1:0] sat_prod(input logic signed [2*W-1:0] p);
        logic signed [2*W-1:0] s;
        s = p >>> F;
        if (s > (2*W)'(SMAX)) begin
            return SMAX;
        end else if (s < (2*W)'(SMIN)) begin
            return SMIN;
        end
        return s[W-1:0];
    endfunction

    assign en_b    = !r_vb || i_ready;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign wr      = i_valid && en_a && (i_ld.mode == vptw_pkg::MODE_LOAD)
                     && (i_ld.sel == SEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i % 5 == 0) ? ONE : '0;
            end
        end else if (wr) begin
            r_mat[{i_ld.row, i_ld.col}] <= i_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) r_va <= i_valid;
            if (en_b) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_ld_a   <= i_ld;
            r_coef_a <= i_coef;
            for (int i = 0; i < 16; i++) begin
                r_prod[i] <= (2*W)'(r_mat[i]) * (2*W)'(i_vec[i % 4]);
            end
        end
    end

    always_comb begin
        logic signed [W+1:0] acc;
        for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int c = 0; c < 4; c++) begin
                acc = acc + (W+2)'(sat_prod(r_prod[r*4 + c]));
            end
            if (acc > (W+2)'(SMAX)) begin
                n_vec_b[r] = SMAX;
            end else if (acc < (W+2)'(SMIN)) begin
                n_vec_b[r] = SMIN;
            end else begin
                n_vec_b[r] = acc[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_ld_b   <= r_ld_a;
            r_coef_b <= r_coef_a;
            r_vec_b  <= n_vec_b;
        end
    end

    assign o_valid = r_vb;
    assign o_ld    = r_ld_b;
    assign o_coef  = r_coef_b;
    assign o_vec   = r_vec_b;

endmodule

/* sv/vptw_div.sv */
// Pipelined restoring divider: three lanes of (v << F) / w, one quotient bit a stage.
module vptw_div #(
    parameter int W = vptw_pkg::COORD_WIDTH,
    parameter int F = vptw_pkg::FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [W-1:0] i_clip [4],
    input  logic [15:0]         i_eps,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_ok,
    output logic signed [W-1:0] o_q [3]
);
    localparam int N = W + F;
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [N-1:0] LIM_POS = N'({1'b0, {(W-1){1'b1}}});
    localparam logic [N-1:0] LIM_NEG = N'({1'b1, {(W-1){1'b0}}});

    logic           r_v   [N+1];
    logic           r_ok  [N+1];
    logic [W-1:0]   r_ud  [N+1];
    logic           r_neg [N+1][3];
    logic [W-1:0]   r_rem [N+1][3];
    logic [N-1:0]   r_dvd [N+1][3];
    logic [N-1:0]   r_quo [N+1][3];
    logic           en    [N+1];
    logic           en_out;
    logic           r_out_v;
    logic           r_out_ok;
    logic signed [W-1:0] r_q [3];
    logic [W-1:0]   mag_w;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        return x[W-1] ? W'(-x) : W'(x);
    endfunction

    assign en_out  = !r_out_v || i_ready;
    assign en[N]   = !r_v[N] || en_out;
    assign o_ready = en[0];
    assign mag_w   = mag(i_clip[3]);

    for (genvar k = 0; k < N; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ok[0] <= mag_w > W'(i_eps);
            r_ud[0] <= mag_w;
            for (int l = 0; l < 3; l++) begin
                r_neg[0][l] <= i_clip[l][W-1] ^ i_clip[3][W-1];
                r_rem[0][l] <= '0;
                r_dvd[0][l] <= {mag(i_clip[l]), {F{1'b0}}};
                r_quo[0][l] <= '0;
            end
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_step
        logic [W-1:0] n_rem [3];
        logic         n_bit [3];

        always_comb begin
            logic [W:0] cand;
            logic [W:0] diff;
            for (int l = 0; l < 3; l++) begin
                cand = {r_rem[k-1][l], r_dvd[k-1][l][N-1]};
                diff = cand - {1'b0, r_ud[k-1]};
                n_bit[l] = cand >= {1'b0, r_ud[k-1]};
                n_rem[l] = n_bit[l] ? diff[W-1:0] : cand[W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_ok[k] <= r_ok[k-1];
                r_ud[k] <= r_ud[k-1];
                for (int l = 0; l < 3; l++) begin
                    r_neg[k][l] <= r_neg[k-1][l];
                    r_rem[k][l] <= n_rem[l];
                    r_dvd[k][l] <= r_dvd[k-1][l] << 1;
                    r_quo[k][l] <= {r_quo[k-1][l][N-2:0], n_bit[l]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_ok <= r_ok[N];
            for (int l = 0; l < 3; l++) begin
                if (r_quo[N][l] > (r_neg[N][l] ? LIM_NEG : LIM_POS)) begin
                    r_q[l] <= r_neg[N][l] ? SMIN : SMAX;
                end else if (r_neg[N][l]) begin
                    r_q[l] <= -$signed(r_quo[N][l][W-1:0]);
                end else begin
                    r_q[l] <= $signed(r_quo[N][l][W-1:0]);
                end
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_ok    = r_out_ok;
    assign o_q     = r_q;

endmodule

/* sv/vptw_vp.sv */
// Depth range mapping and viewport scaling with saturation.
module vptw_vp #(
    parameter int W = vptw_pkg::COORD_WIDTH,
    parameter int F = vptw_pkg::FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_ok,
    input  logic signed [W-1:0] i_q [3],
    input  logic signed [15:0]  i_vx,
    input  logic signed [15:0]  i_vy,
    input  logic [14:0]         i_vw,
    input  logic [14:0]         i_vh,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [W-1:0] o_win_x,
    output logic signed [W-1:0] o_win_y,
    output logic signed [W-1:0] o_win_z,
    output logic                o_ok
);
    localparam int HW = ((W > F) ? W : F + 1) + 1;
    localparam int PW = HW + 16;
    localparam int SW = ((W > 16 + F) ? W : 16 + F) + 1;
    localparam logic signed [HW-1:0] HALF = HW'(longint'(1) <<< (F - 1));
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    logic                 r_vh, r_vm, r_vs;
    logic                 r_ok_h, r_ok_m, r_ok_s;
    logic signed [HW-1:0] r_h [3];
    logic signed [PW-1:0] r_px, r_py;
    logic signed [W-1:0]  r_z_m;
    logic signed [W-1:0]  r_wx, r_wy, r_wz;
    logic                 en_h, en_m, en_s;

    function automatic logic signed [W-1:0] sat_h(input logic signed [HW-1:0] v);
        if (v > HW'(SMAX)) return SMAX;
        if (v < HW'(SMIN)) return SMIN;
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_p(input logic signed [PW-1:0] v);
        if (v > PW'(SMAX)) return SMAX;
        if (v < PW'(SMIN)) return SMIN;
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] place(input logic signed [PW-1:0] p,
                                                  input logic signed [15:0] edge_px);
        logic signed [SW-1:0] s;
        s = SW'(sat_p(p)) + (SW'(edge_px) <<< F);
        if (s > SW'(SMAX)) return SMAX;
        if (s < SW'(SMIN)) return SMIN;
        return s[W-1:0];
    endfunction

    assign en_s    = !r_vs || i_ready;
    assign en_m    = !r_vm || en_s;
    assign en_h    = !r_vh || en_m;
    assign o_ready = en_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vh <= 1'b0;
            r_vm <= 1'b0;
            r_vs <= 1'b0;
        end else begin
            if (en_h) r_vh <= i_valid;
            if (en_m) r_vm <= r_vh;
            if (en_s) r_vs <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_h) begin
            r_ok_h <= i_ok;
            for (int l = 0; l < 3; l++) begin
                r_h[l] <= HALF + HW'(i_q[l] >>> 1);
            end
        end
        if (en_m) begin
            r_ok_m <= r_ok_h;
            r_px   <= PW'(r_h[0]) * PW'($signed({1'b0, i_vw}));
            r_py   <= PW'(r_h[1]) * PW'($signed({1'b0, i_vh}));
            r_z_m  <= sat_h(r_h[2]);
        end
        if (en_s) begin
            r_ok_s <= r_ok_m;
            if (r_ok_m) begin
                r_wx <= place(r_px, i_vx);
                r_wy <= place(r_py, i_vy);
                r_wz <= r_z_m;
            end else begin
                r_wx <= '0;
                r_wy <= '0;
                r_wz <= '0;
            end
        end
    end

    assign o_valid = r_vs;
    assign o_ok    = r_ok_s;
    assign o_win_x = r_wx;
    assign o_win_y = r_wy;
    assign o_win_z = r_wz;

endmodule

/* sv/vertex_project_to_window_unit.sv */
// Top level of the vertex projection unit: config registers and pipeline.
//   channel  dir  handshake      payload
//   i_vtx    in   valid/ready    mode, matrix_select, row/column, coefficient, obj_x/y/z
//   o_win    out  valid/ready    win_x, win_y, win_z, projected_ok
//   i_cfg    in   i_cfg_wr_en    i_cfg_index, i_cfg_data
// One request per cycle while o_win is not stalled; the divider resolves one quotient
// bit per stage.
// Synchronous active-low reset clears valids, resets config, sets matrices to identity.
// Each stage holds while its successor is full and stalled; bubbles close up.
module vertex_project_to_window_unit #(
    parameter int COORD_WIDTH = vptw_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = vptw_pkg::FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    vptw_in_if.sink                           i_vtx,
    vptw_out_if.source                        o_win,
    input  logic                              i_cfg_wr_en,
    input  logic [vptw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vptw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int W = COORD_WIDTH;
    localparam int F = FRAC_BITS;
    localparam longint ONE_I = (F >= W - 1) ? ((longint'(1) <<< (W - 1)) - 1)
                                            : (longint'(1) <<< F);
    localparam logic signed [W-1:0] ONE = W'(ONE_I);

    logic signed [15:0] r_vx, r_vy;
    logic [14:0]        r_vw, r_vh;
    logic [15:0]        r_eps;

    vptw_pkg::t_ld       in_ld;
    logic signed [W-1:0] in_vec [4];

    logic                m1_valid, m1_ready;
    vptw_pkg::t_ld       m1_ld;
    logic signed [W-1:0] m1_coef;
    logic signed [W-1:0] m1_vec [4];

    logic                m2_valid, m2_ready;
    vptw_pkg::t_ld       m2_ld;
    logic signed [W-1:0] m2_vec [4];

    logic                d_valid, d_ready, d_ok;
    logic signed [W-1:0] d_q [3];

    logic                vp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx  <= vptw_pkg::VP_X_RESET;
            r_vy  <= vptw_pkg::VP_Y_RESET;
            r_vw  <= vptw_pkg::VP_W_RESET;
            r_vh  <= vptw_pkg::VP_H_RESET;
            r_eps <= vptw_pkg::W_EPS_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                vptw_pkg::CFG_VIEWPORT_X:      r_vx  <= i_cfg_data;
                vptw_pkg::CFG_VIEWPORT_Y:      r_vy  <= i_cfg_data;
                vptw_pkg::CFG_VIEWPORT_WIDTH:  r_vw  <= i_cfg_data[14:0];
                vptw_pkg::CFG_VIEWPORT_HEIGHT: r_vh  <= i_cfg_data[14:0];
                vptw_pkg::CFG_W_EPSILON:       r_eps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ld.mode = i_vtx.mode;
    assign in_ld.sel  = i_vtx.matrix_select;
    assign in_ld.row  = i_vtx.row_index;
    assign in_ld.col  = i_vtx.column_index;
    assign in_vec[0]  = i_vtx.obj_x;
    assign in_vec[1]  = i_vtx.obj_y;
    assign in_vec[2]  = i_vtx.obj_z;
    assign in_vec[3]  = ONE;
    assign i_vtx.ready = m1_ready;

    vptw_mat_stage #(.W(W), .F(F), .SEL(vptw_pkg::SEL_MODEL_VIEW)) u_model_view (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vtx.valid),
        .o_ready (m1_ready),
        .i_ld    (in_ld),
        .i_coef  (i_vtx.coefficient),
        .i_vec   (in_vec),
        .o_valid (m1_valid),
        .i_ready (m2_ready),
        .o_ld    (m1_ld),
        .o_coef  (m1_coef),
        .o_vec   (m1_vec)
    );

    vptw_mat_stage #(.W(W), .F(F), .SEL(vptw_pkg::SEL_PROJECTION)) u_projection (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m1_valid),
        .o_ready (m2_ready),
        .i_ld    (m1_ld),
        .i_coef  (m1_coef),
        .i_vec   (m1_vec),
        .o_valid (m2_valid),
        .i_ready (d_ready),
        .o_ld    (m2_ld),
        .o_coef  (),
        .o_vec   (m2_vec)
    );

    vptw_div #(.W(W), .F(F)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m2_valid && (m2_ld.mode == vptw_pkg::MODE_PROJECT)),
        .o_ready (d_ready),
        .i_clip  (m2_vec),
        .i_eps   (r_eps),
        .o_valid (d_valid),
        .i_ready (vp_ready),
        .o_ok    (d_ok),
        .o_q     (d_q)
    );

    vptw_vp #(.W(W), .F(F)) u_vp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .o_ready (vp_ready),
        .i_ok    (d_ok),
        .i_q     (d_q),
        .i_vx    (r_vx),
        .i_vy    (r_vy),
        .i_vw    (r_vw),
        .i_vh    (r_vh),
        .o_valid (o_win.valid),
        .i_ready (o_win.ready),
        .o_win_x (o_win.win_x),
        .o_win_y (o_win.win_y),
        .o_win_z (o_win.win_z),
        .o_ok    (o_win.projected_ok)
    );

endmodule
